// ===== hdl/mtwg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtwg_pkg
// shared types and constants of the mt19937 word generator: item kinds,
// sequencer states and the command and status groups between the two halves
// ----------------------------------------------------------------------------
package mtwg_pkg;

  // twister geometry
  localparam int unsigned TW_N = 624;
  localparam int unsigned TW_M = 397;

  // twister constants
  localparam logic [31:0] TW_MATRIX  = 32'h9908_b0df;
  localparam logic [31:0] TW_UPPER   = 32'h8000_0000;
  localparam logic [31:0] TW_LOWER   = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MULT  = 32'd1812433253;
  localparam logic [31:0] MIX1_MULT  = 32'd1664525;
  localparam logic [31:0] MIX2_MULT  = 32'd1566083941;
  localparam logic [31:0] ARRAY_SEED = 32'd19650218;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc6_0000;

  // item kinds
  typedef enum logic [1:0] {
    KIND_SEED = 2'd0,
    KIND_KEY  = 2'd1,
    KIND_DRAW = 2'd2
  } kind_t;

  // multiplier constant select
  typedef enum logic [1:0] {
    MUL_SEED = 2'd0,
    MUL_MIX1 = 2'd1,
    MUL_MIX2 = 2'd2
  } mul_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_MIX_INIT,
    ST_MIX1_RD,
    ST_MIX1_WR,
    ST_MIX2_RD,
    ST_MIX2_WR,
    ST_MIX_FIN,
    ST_TW_PRIME,
    ST_TW_RD,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } state_t;

  // commands from sequencer to datapath
  typedef struct packed {
    logic     seed_init;
    logic     seed_const;
    logic     key_write;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     seed_step;
    logic     mix_init;
    logic     mix_rd;
    logic     mix1_step;
    logic     mix2_start;
    logic     mix2_step;
    logic     mix_fin;
    logic     tw_prime;
    logic     tw_rd;
    logic     tw_step;
    logic     draw_rd;
    logic     draw_out;
    logic     out_zero;
  } cmd_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic seeded;
    logic idx_full;
    logic i_last;
    logic k_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== hdl/mtwg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtwg_ctrl
// sequencer: takes items and steps the datapath through seeding, key mixing,
// twisting and word reads
// ----------------------------------------------------------------------------
module mtwg_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     kind,
  input  wire logic           last,
  input  mtwg_pkg::stat_t     stat,
  output mtwg_pkg::cmd_t      cmd,
  output logic                busy
);
  import mtwg_pkg::*;

  state_t state;
  state_t state_next;
  logic   key_flow;
  logic   key_flow_next;
  logic   accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      key_flow <= 1'b0;
    end else begin
      state    <= state_next;
      key_flow <= key_flow_next;
    end
  end

  // next state
  always_comb begin
    state_next    = state;
    key_flow_next = key_flow;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_SEED: begin
              state_next    = ST_SEED_MUL;
              key_flow_next = 1'b0;
            end
            KIND_KEY: begin
              if (last) begin
                state_next    = ST_SEED_MUL;
                key_flow_next = 1'b1;
              end
            end
            KIND_DRAW: begin
              if (stat.seeded) begin
                state_next = stat.idx_full ? ST_TW_PRIME : ST_DRAW_OUT;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEED_MUL: state_next = ST_SEED_ADD;
      ST_SEED_ADD: begin
        if (stat.i_last) begin
          state_next = key_flow ? ST_MIX_INIT : ST_IDLE;
        end else begin
          state_next = ST_SEED_MUL;
        end
      end
      ST_MIX_INIT: state_next = ST_MIX1_RD;
      ST_MIX1_RD:  state_next = ST_MIX1_WR;
      ST_MIX1_WR:  state_next = stat.k_last ? ST_MIX2_RD : ST_MIX1_RD;
      ST_MIX2_RD:  state_next = ST_MIX2_WR;
      ST_MIX2_WR:  state_next = stat.k_last ? ST_MIX_FIN : ST_MIX2_RD;
      ST_MIX_FIN:  state_next = ST_IDLE;
      ST_TW_PRIME: state_next = ST_TW_RD;
      ST_TW_RD:    state_next = ST_TW_WR;
      ST_TW_WR:    state_next = stat.i_last ? ST_DRAW_RD : ST_TW_RD;
      ST_DRAW_RD:  state_next = ST_DRAW_OUT;
      ST_DRAW_OUT: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_SEED: cmd.seed_init = 1'b1;
            KIND_KEY: begin
              cmd.key_write = 1'b1;
              if (last) begin
                cmd.seed_init  = 1'b1;
                cmd.seed_const = 1'b1;
              end
            end
            KIND_DRAW: begin
              if (!stat.seeded) begin
                cmd.out_zero = 1'b1;
              end else if (!stat.idx_full) begin
                cmd.draw_rd = 1'b1;
              end
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_SEED_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_SEED;
      end
      ST_SEED_ADD: cmd.seed_step = 1'b1;
      ST_MIX_INIT: cmd.mix_init = 1'b1;
      ST_MIX1_RD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MIX1;
        cmd.mix_rd  = 1'b1;
      end
      ST_MIX1_WR: begin
        cmd.mix1_step  = 1'b1;
        cmd.mix2_start = stat.k_last;
      end
      ST_MIX2_RD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MIX2;
        cmd.mix_rd  = 1'b1;
      end
      ST_MIX2_WR:  cmd.mix2_step = 1'b1;
      ST_MIX_FIN:  cmd.mix_fin = 1'b1;
      ST_TW_PRIME: cmd.tw_prime = 1'b1;
      ST_TW_RD:    cmd.tw_rd = 1'b1;
      ST_TW_WR:    cmd.tw_step = 1'b1;
      ST_DRAW_RD:  cmd.draw_rd = 1'b1;
      ST_DRAW_OUT: cmd.draw_out = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/mtwg_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtwg_dp
// datapath: twister state memory, key store, shared multiplier, index
// counters, tempering and the result register
// ----------------------------------------------------------------------------
module mtwg_dp #(
  parameter int unsigned KEY_WORDS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [31:0]    value,
  input  mtwg_pkg::cmd_t      cmd,
  output mtwg_pkg::stat_t     stat,
  output logic [31:0]         number,
  output logic                strobe
);
  import mtwg_pkg::*;

  localparam int unsigned KCW  = $clog2(KEY_WORDS + 1);
  localparam int unsigned KAW  = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int unsigned KMAX = (KEY_WORDS > TW_N) ? KEY_WORDS : TW_N;
  localparam int unsigned KNW  = $clog2(KMAX + 1);
  localparam int unsigned LW   = KCW + 1;

  localparam logic [9:0] N_LAST = 10'(TW_N - 1);
  localparam logic [9:0] N_FULL = 10'(TW_N);
  localparam logic [9:0] N_M    = 10'(TW_N - TW_M);
  localparam logic [9:0] M_OFF  = 10'(TW_M);

  logic [31:0] tw_mem  [0:TW_N-1];
  logic [31:0] key_mem [0:KEY_WORDS-1];

  logic [31:0]    rd_a;
  logic [31:0]    rd_b;
  logic [31:0]    rd_k;
  logic [31:0]    prev;
  logic [31:0]    prod;
  logic [9:0]     i;
  logic [KAW-1:0] j;
  logic [KNW-1:0] k;
  logic [9:0]     idx;
  logic [KCW-1:0] key_count;
  logic           seeded;
  logic           cur_msb;

  logic [9:0]     i_plus1;
  logic [9:0]     i_plus_m;
  logic [9:0]     i_wrap;
  logic [9:0]     addr_a;
  logic           re_a;
  logic           wr_en;
  logic [9:0]     wr_addr;
  logic [31:0]    wr_data;
  logic [31:0]    seed_val;
  logic [31:0]    step_val;
  logic [31:0]    mul_x;
  logic [31:0]    mul_c;
  logic [31:0]    prod_next;
  logic [31:0]    kw;
  logic [31:0]    tw_y;
  logic [31:0]    tw_val;
  logic [KCW-1:0] key_len;
  logic [KNW-1:0] k_init;
  logic [KAW-1:0] j_next;
  logic           key_we;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // index arithmetic
  assign i_plus1  = (i == N_LAST) ? 10'd0 : i + 10'd1;
  assign i_plus_m = (i >= N_M) ? i - N_M : i + M_OFF;
  assign i_wrap   = (i == N_LAST) ? 10'd1 : i + 10'd1;

  // key length used by the array initialisation
  assign key_len = (key_count == '0) ? KCW'(1) : key_count;
  assign k_init  = (KNW'(key_len) > KNW'(TW_N)) ? KNW'(key_len) : KNW'(TW_N);
  assign j_next  = ((LW'(j) + LW'(1)) >= LW'(key_len)) ? '0 : j + KAW'(1);
  assign kw      = (key_count == '0) ? 32'd0 : rd_k;
  assign key_we  = cmd.key_write && (key_count < KCW'(KEY_WORDS));

  // shared multiplier, low word only
  assign mul_x = prev ^ (prev >> 30);
  always_comb begin
    case (cmd.mul_sel)
      MUL_SEED: mul_c = SEED_MULT;
      MUL_MIX1: mul_c = MIX1_MULT;
      MUL_MIX2: mul_c = MIX2_MULT;
      default:  mul_c = SEED_MULT;
    endcase
  end
  assign prod_next = mul_x * mul_c;

  // twist step
  assign tw_y   = {cur_msb, rd_a[30:0]};
  assign tw_val = rd_b ^ (tw_y >> 1) ^ (tw_y[0] ? TW_MATRIX : 32'd0);

  assign seed_val = cmd.seed_const ? ARRAY_SEED : value;

  always_comb begin
    if (cmd.mix1_step) begin
      step_val = (rd_a ^ prod) + kw + {{(32-KAW){1'b0}}, j};
    end else if (cmd.mix2_step) begin
      step_val = (rd_a ^ prod) - {22'd0, i};
    end else begin
      step_val = prod + {22'd0, i};
    end
  end

  // state memory write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = i;
    wr_data = step_val;
    if (cmd.seed_init) begin
      wr_en   = 1'b1;
      wr_addr = 10'd0;
      wr_data = seed_val;
    end else if (cmd.mix_fin) begin
      wr_en   = 1'b1;
      wr_addr = 10'd0;
      wr_data = TW_UPPER;
    end else if (cmd.tw_step) begin
      wr_en   = 1'b1;
      wr_data = tw_val;
    end else if (cmd.seed_step || cmd.mix1_step || cmd.mix2_step) begin
      wr_en   = 1'b1;
    end
  end

  // state memory read port a
  always_comb begin
    re_a   = 1'b1;
    addr_a = i;
    if (cmd.draw_rd) begin
      addr_a = idx;
    end else if (cmd.tw_prime) begin
      addr_a = 10'd0;
    end else if (cmd.tw_rd) begin
      addr_a = i_plus1;
    end else if (!cmd.mix_rd) begin
      re_a   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tw_mem[wr_addr] <= wr_data;
    end
    if (re_a) begin
      rd_a <= tw_mem[addr_a];
    end
    if (cmd.tw_rd) begin
      rd_b <= tw_mem[i_plus_m];
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count[KAW-1:0]] <= value;
    end
    if (cmd.mix_rd) begin
      rd_k <= key_mem[j];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
    if (cmd.seed_init) begin
      prev <= seed_val;
    end else if (cmd.mix_init) begin
      prev <= ARRAY_SEED;
    end else if (cmd.seed_step || cmd.mix1_step || cmd.mix2_step) begin
      prev <= step_val;
    end
    if (cmd.tw_rd) begin
      cur_msb <= rd_a[31];
    end
    if (cmd.draw_out) begin
      number <= temper(rd_a);
    end else if (cmd.out_zero) begin
      number <= 32'd0;
    end
    if (cmd.mix_init) begin
      j <= '0;
    end else if (cmd.mix1_step) begin
      j <= j_next;
    end
    if (cmd.mix_init) begin
      k <= k_init;
    end else if (cmd.mix2_start) begin
      k <= KNW'(TW_N - 1);
    end else if (cmd.mix1_step || cmd.mix2_step) begin
      k <= k - KNW'(1);
    end
    if (cmd.seed_init || cmd.mix_init) begin
      i <= 10'd1;
    end else if (cmd.tw_prime) begin
      i <= 10'd0;
    end else if (cmd.seed_step || cmd.tw_step) begin
      i <= i + 10'd1;
    end else if (cmd.mix1_step || cmd.mix2_step) begin
      i <= i_wrap;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= N_FULL;
      seeded    <= 1'b0;
      key_count <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= cmd.draw_out || cmd.out_zero;
      if (cmd.seed_init) begin
        seeded <= 1'b1;
      end
      if (cmd.seed_init) begin
        idx <= N_FULL;
      end else if (cmd.tw_step && (i == N_LAST)) begin
        idx <= 10'd0;
      end else if (cmd.draw_rd) begin
        idx <= idx + 10'd1;
      end
      if (cmd.mix_fin) begin
        key_count <= '0;
      end else if (key_we) begin
        key_count <= key_count + KCW'(1);
      end
    end
  end

  assign stat.seeded   = seeded;
  assign stat.idx_full = (idx >= N_FULL);
  assign stat.i_last   = (i == N_LAST);
  assign stat.k_last   = (k == KNW'(1));

  // once seeded each draw reads, then outputs: results never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
      (strobe && seeded) |=> !strobe)
    else $error("seeded result strobe high in two consecutive cycles");

  a_idx_range: assert property (@(posedge clk) disable iff (rst) idx <= N_FULL)
    else $error("word index beyond state size");

  a_draw_ok: assert property (@(posedge clk) disable iff (rst)
      cmd.draw_rd |-> (seeded && (idx < N_FULL)))
    else $error("word read from unseeded or exhausted state");

  a_mix_addr: assert property (@(posedge clk) disable iff (rst)
      (cmd.mix1_step || cmd.mix2_step) |-> ((i != 10'd0) && (i < N_FULL)))
    else $error("key mixing wrote outside words one to last");

endmodule
`default_nettype wire

// ===== hdl/mt19937_word_generator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mt19937_word_generator_top
// mt19937 generator with single-word seeding, key array seeding and tempered
// 32-bit word output
// ----------------------------------------------------------------------------
// usage
//   an item is taken at a rising edge with start high and busy low; kind
//   selects seed (value is the seed), key word (value is appended to the key
//   store, last starts the array initialisation) or draw
//   a draw gives one result: number with strobe high for exactly one cycle;
//   the receiver cannot hold results off, and none is ever held back
// item handling
//   draw: the word is read when the draw is taken, then tempered into
//     number and strobe in the draw output state, busy only there; before
//     any seed the zero word is registered, never busy, one draw a cycle
//   every 624th draw first twists the state: a prime step, then a read and
//     a write step for each word through the state memory, all busy
//   seed: busy for a multiply and an add step on each of words 1 to 623
//   key word: never busy; the last one runs the seeding, a setup step,
//     mixing over max(624, key words) words, then over 623 words, and a
//     final write, all paced by the multiplier and the state memory port
//   unused kind: ignored, no result
// reset
//   index to 624, key count to zero; the state reads as all zeros through
//   a seeded flag, so draws before any seed give zero, no clearing pass
// ----------------------------------------------------------------------------
module mt19937_word_generator_top #(
  parameter int unsigned KEY_WORDS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] value,
  input  wire logic        last,
  output logic [31:0]      number,
  output logic             strobe
);
  import mtwg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: item decode and step control
  mtwg_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .last  (last),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath: state memory, key store, multiplier, tempering
  mtwg_dp #(
    .KEY_WORDS (KEY_WORDS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .value  (value),
    .cmd    (cmd),
    .stat   (stat),
    .number (number),
    .strobe (strobe)
  );

endmodule
`default_nettype wire
